>>> rtl/dscd_pkg.sv
// Shared types and constants for the delta stream command decoder.
// Used by dscd_decoder, dscd_outq and delta_stream_command_decoder; depends on nothing.
package dscd_pkg;

  localparam logic [6:0]  HDR_PAYLOAD_MASK = 7'h7f;
  localparam logic [7:0]  HDR_CONT_BIT     = 8'h80;
  localparam logic [23:0] COPY_LEN_ZERO    = 24'h010000;
  localparam int          HDR_STEP         = 7;
  localparam int          OQ_DEPTH         = 4;
  localparam int          OQ_CNT_W         = 3;

  typedef enum logic [2:0] {
    PH_PARENT = 3'd0,
    PH_TARGET = 3'd1,
    PH_CMD    = 3'd2,
    PH_COPY   = 3'd3,
    PH_INSERT = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    KIND_TARGET  = 3'd0,
    KIND_COPY    = 3'd1,
    KIND_LITERAL = 3'd2,
    KIND_DONE    = 3'd3,
    KIND_ERROR   = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE    = 3'd0,
    ERR_PARENT  = 3'd1,
    ERR_BADCOPY = 3'd2,
    ERR_OVERRUN = 3'd3,
    ERR_ZEROCMD = 3'd4,
    ERR_TRUNC   = 3'd5,
    ERR_LONG    = 3'd6
  } err_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] copy_offset;
    logic [23:0] copy_length;
    logic [7:0]  literal_byte;
    logic [31:0] object_size;
    err_t        error_code;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

>>> rtl/dscd_decoder.sv
// Stream state and per-byte decode logic of the delta stream command decoder.
// Produces up to two result items per accepted byte; depends on dscd_pkg.
module dscd_decoder #(
  parameter int SIZE_BITS = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            accept,
  input  logic [7:0]      delta_byte,
  input  logic            last_byte,
  input  logic            cfg_wr_en,
  input  logic [31:0]     cfg_wr_data,
  output dscd_pkg::push_t push
);
  import dscd_pkg::*;

  localparam int SB   = SIZE_BITS;
  localparam int SC_W = $clog2(SIZE_BITS + HDR_STEP + 1);

  logic [31:0]   exp_r;
  phase_t        phase_r, phase_nxt;
  logic [SB-1:0] acc_r, acc_nxt;
  logic [SC_W-1:0] sc_r, sc_nxt;
  logic [SB-1:0] decl_r, decl_nxt;
  logic [SB-1:0] rem_r, rem_nxt;
  logic [6:0]    flags_r, flags_nxt;
  logic [31:0]   off_r, off_nxt;
  logic [23:0]   len_r, len_nxt;
  logic [6:0]    lit_r, lit_nxt;
  logic          errl_r, errl_nxt;

  logic [6:0]      payload;
  logic [SC_W-1:0] room;
  logic            hdr_long;
  logic [SB+6:0]   hdr_shift;
  logic [SB-1:0]   hdr_acc;
  logic [SB+31:0]  hdr_ext;
  logic [6:0]      flag_low;
  logic [6:0]      flags_upd;
  logic [31:0]     off_upd;
  logic [23:0]     len_upd;
  logic [31:0]     fin_off;
  logic [23:0]     fin_len;
  logic [23:0]     len_eff;
  logic [SB+32:0]  copy_end;
  logic            copy_bad;
  logic [SB+23:0]  rem_copy;
  logic [SB+7:0]   rem_ins;
  logic [6:0]      lit_dec;
  err_t            err;
  logic            main_v;
  result_t         main_r;
  logic            tail_v;
  result_t         tail_r;

  assign payload   = delta_byte[6:0] & HDR_PAYLOAD_MASK;
  assign room      = SC_W'(SB) - sc_r;
  assign hdr_long  = (sc_r >= SC_W'(SB)) || ((payload & (HDR_PAYLOAD_MASK << room)) != 7'd0);
  assign hdr_shift = {{SB{1'b0}}, payload} << sc_r;
  assign hdr_acc   = acc_r | hdr_shift[SB-1:0];
  assign hdr_ext   = {32'd0, hdr_acc};

  assign flag_low  = flags_r & (~flags_r + 7'd1);
  assign flags_upd = flags_r & ~flag_low;
  always_comb begin
    off_upd = off_r;
    len_upd = len_r;
    for (int k = 0; k < 4; k++) begin
      if (flag_low[k]) off_upd[8*k +: 8] = off_r[8*k +: 8] | delta_byte;
    end
    for (int k = 0; k < 3; k++) begin
      if (flag_low[k+4]) len_upd[8*k +: 8] = len_r[8*k +: 8] | delta_byte;
    end
  end

  assign fin_off  = (phase_r == PH_COPY) ? off_upd : 32'd0;
  assign fin_len  = (phase_r == PH_COPY) ? len_upd : 24'd0;
  assign len_eff  = (fin_len == 24'd0) ? COPY_LEN_ZERO : fin_len;
  assign copy_end = {{(SB+1){1'b0}}, fin_off} + {{(SB+9){1'b0}}, len_eff};
  assign copy_bad = (copy_end > {33'd0, decl_r}) ||
                    ({{SB{1'b0}}, len_eff} > {24'd0, rem_r});
  assign rem_copy = {24'd0, rem_r} - {{SB{1'b0}}, len_eff};
  assign rem_ins  = {8'd0, rem_r} - {{SB{1'b0}}, delta_byte};
  assign lit_dec  = (lit_r == 7'd0) ? 7'd0 : lit_r - 7'd1;

  always_comb begin : next_state
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    sc_nxt    = sc_r;
    decl_nxt  = decl_r;
    rem_nxt   = rem_r;
    flags_nxt = flags_r;
    off_nxt   = off_r;
    len_nxt   = len_r;
    lit_nxt   = lit_r;
    errl_nxt  = errl_r;
    err       = ERR_NONE;
    main_v    = 1'b0;
    main_r    = '0;
    if (!errl_r) begin
      unique case (phase_r)
        PH_PARENT, PH_TARGET: begin
          if (hdr_long) begin
            err = ERR_LONG;
          end else begin
            acc_nxt = hdr_acc;
            sc_nxt  = sc_r + SC_W'(HDR_STEP);
            if (!delta_byte[7]) begin
              if (phase_r == PH_PARENT) begin
                decl_nxt = hdr_acc;
                if (hdr_ext != {{SB{1'b0}}, exp_r}) begin
                  err = ERR_PARENT;
                end else begin
                  phase_nxt = PH_TARGET;
                  acc_nxt   = '0;
                  sc_nxt    = '0;
                end
              end else begin
                main_v             = 1'b1;
                main_r.kind        = KIND_TARGET;
                main_r.object_size = hdr_ext[31:0];
                rem_nxt            = hdr_acc;
                phase_nxt          = PH_CMD;
              end
            end
          end
        end
        PH_CMD: begin
          if ((delta_byte & HDR_CONT_BIT) != 8'd0) begin
            flags_nxt = delta_byte[6:0];
            off_nxt   = '0;
            len_nxt   = '0;
            if (delta_byte[6:0] == 7'd0) begin
              if (copy_bad) begin
                err = ERR_BADCOPY;
              end else begin
                main_v             = 1'b1;
                main_r.kind        = KIND_COPY;
                main_r.copy_offset = fin_off;
                main_r.copy_length = len_eff;
                rem_nxt            = rem_copy[SB-1:0];
              end
            end else begin
              phase_nxt = PH_COPY;
            end
          end else if (delta_byte != 8'd0) begin
            if ({{SB{1'b0}}, delta_byte} > {8'd0, rem_r}) begin
              err = ERR_OVERRUN;
            end else begin
              lit_nxt   = delta_byte[6:0];
              rem_nxt   = rem_ins[SB-1:0];
              phase_nxt = PH_INSERT;
            end
          end else begin
            err = ERR_ZEROCMD;
          end
        end
        PH_COPY: begin
          off_nxt   = off_upd;
          len_nxt   = len_upd;
          flags_nxt = flags_upd;
          if (flags_upd == 7'd0) begin
            phase_nxt = PH_CMD;
            if (copy_bad) begin
              err = ERR_BADCOPY;
            end else begin
              main_v             = 1'b1;
              main_r.kind        = KIND_COPY;
              main_r.copy_offset = fin_off;
              main_r.copy_length = len_eff;
              rem_nxt            = rem_copy[SB-1:0];
            end
          end
        end
        PH_INSERT: begin
          main_v              = 1'b1;
          main_r.kind         = KIND_LITERAL;
          main_r.literal_byte = delta_byte;
          lit_nxt             = lit_dec;
          if (lit_dec == 7'd0) phase_nxt = PH_CMD;
        end
        default: begin
          phase_nxt = PH_CMD;
        end
      endcase
      if (err != ERR_NONE) errl_nxt = 1'b1;
    end
  end

  always_comb begin : outputs
    tail_v = !errl_r && ((err != ERR_NONE) || last_byte);
    tail_r = '0;
    if (err != ERR_NONE) begin
      tail_r.kind       = KIND_ERROR;
      tail_r.error_code = err;
    end else if ((phase_nxt == PH_CMD) && (rem_nxt == '0)) begin
      tail_r.kind = KIND_DONE;
    end else begin
      tail_r.kind       = KIND_ERROR;
      tail_r.error_code = ERR_TRUNC;
    end
    tail_r.last = 1'b1;
    push    = '0;
    push.r0 = main_r;
    if (accept) begin
      push.n = {1'b0, main_v} + {1'b0, tail_v};
      if (main_v && tail_v) begin
        push.r1 = tail_r;
      end else if (tail_v) begin
        push.r0 = tail_r;
      end else begin
        push.r0.last = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r <= '0;
    end else if (cfg_wr_en) begin
      exp_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (accept && last_byte)) begin
      phase_r <= PH_PARENT;
      acc_r   <= '0;
      sc_r    <= '0;
      decl_r  <= '0;
      rem_r   <= '0;
      flags_r <= '0;
      off_r   <= '0;
      len_r   <= '0;
      lit_r   <= '0;
      errl_r  <= 1'b0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      sc_r    <= sc_nxt;
      decl_r  <= decl_nxt;
      rem_r   <= rem_nxt;
      flags_r <= flags_nxt;
      off_r   <= off_nxt;
      len_r   <= len_nxt;
      lit_r   <= lit_nxt;
      errl_r  <= errl_nxt;
    end
  end

`ifndef SYNTHESIS
  a_latched_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && errl_r) |-> (push.n == 2'd0))
    else $error("results produced after a latched fault");
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && last_byte) |=> ((phase_r == PH_PARENT) && !errl_r && (rem_r == '0)))
    else $error("state not restarted after the final byte");
  a_last_order: assert property (@(posedge clk) disable iff (!rst_n)
    (push.n == 2'd2) |-> (push.r1.last && !push.r0.last))
    else $error("last flag not on the final result of a byte");
  a_copy_fits: assert property (@(posedge clk) disable iff (!rst_n)
    (push.n != 2'd0 && push.r0.kind == KIND_COPY) |-> (push.r0.copy_length != 24'd0))
    else $error("copy emitted with zero length");
`endif

endmodule

>>> rtl/dscd_outq.sv
// Four-entry shifting result queue between the decoder and the output port.
// Head entry drives the output; takes up to two items per cycle; depends on dscd_pkg.
module dscd_outq (
  input  logic              clk,
  input  logic              rst_n,
  input  dscd_pkg::push_t   push,
  output logic              has_room,
  output logic              out_valid,
  input  logic              out_ready,
  output dscd_pkg::result_t head
);
  import dscd_pkg::*;

  result_t q_r [OQ_DEPTH];
  result_t q_nxt [OQ_DEPTH];
  logic [OQ_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [OQ_CNT_W-1:0] base;
  logic pop;

  assign pop       = (cnt_r != '0) && out_ready;
  assign base      = cnt_r - OQ_CNT_W'(pop);
  assign cnt_nxt   = base + OQ_CNT_W'(push.n);
  assign has_room  = (cnt_r <= OQ_CNT_W'(OQ_DEPTH - 2));
  assign out_valid = (cnt_r != '0);
  assign head      = q_r[0];

  always_comb begin
    for (int i = 0; i < OQ_DEPTH; i++) begin
      if (pop && (i < OQ_DEPTH - 1)) begin
        q_nxt[i] = q_r[(i + 1) % OQ_DEPTH];
      end else begin
        q_nxt[i] = q_r[i];
      end
      if ((push.n != 2'd0) && (base == OQ_CNT_W'(i))) q_nxt[i] = push.r0;
      if ((push.n == 2'd2) && (base + OQ_CNT_W'(1) == OQ_CNT_W'(i))) q_nxt[i] = push.r1;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < OQ_DEPTH; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= OQ_CNT_W'(OQ_DEPTH))
    else $error("result queue overflow");
  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push.n == 2'd0 && !pop) |=> (cnt_r == $past(cnt_r)))
    else $error("result queue count changed without traffic");
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push.n != 2'd0) |-> (cnt_r <= OQ_CNT_W'(OQ_DEPTH - 2)))
    else $error("items pushed into a full result queue");
`endif

endmodule

>>> rtl/delta_stream_command_decoder.sv
// Top level of the delta stream command decoder: decoder plus result queue.
// Depends on dscd_pkg, dscd_decoder and dscd_outq.
//
// The block takes one delta stream byte per clock cycle while in_ready is high
// and decodes it in a single pass into at most two result items, which are
// placed in a four-entry result queue and appear on the output starting the
// cycle after the byte is accepted. in_ready drops only while more than two
// results wait in the queue, so a stalled output holds off the input after
// two or three bytes that produce results. The expected parent size must be
// written by the user through cfg_wr_en and cfg_wr_data only while no stream
// is in progress; the block does not enforce this. After the byte marked as
// last, all stream state is reset and the next stream may follow at once.
module delta_stream_command_decoder #(
  parameter int SIZE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_delta_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_kind,
  output logic [31:0] out_copy_offset,
  output logic [23:0] out_copy_length,
  output logic [7:0]  out_literal_byte,
  output logic [31:0] out_object_size,
  output logic [2:0]  out_error_code,
  output logic        out_last,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data
);
  import dscd_pkg::*;

  push_t   push;
  result_t head;
  logic    accept;

  assign accept = in_valid && in_ready;

  dscd_decoder #(
    .SIZE_BITS (SIZE_BITS)
  ) u_decoder (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .delta_byte  (in_delta_byte),
    .last_byte   (in_last_byte),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .push        (push)
  );

  dscd_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .has_room  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign out_kind         = head.kind;
  assign out_copy_offset  = head.copy_offset;
  assign out_copy_length  = head.copy_length;
  assign out_literal_byte = head.literal_byte;
  assign out_object_size  = head.object_size;
  assign out_error_code   = head.error_code;
  assign out_last         = head.last;

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for delta_stream_command_decoder: directed and random delta streams,
// with every result compared against a decoder model kept in this file.
// Depends on dscd_pkg and the delta_stream_command_decoder RTL.
module testbench;
  import dscd_pkg::*;

  localparam int SIZE_BITS = 32;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_PRINTED = 40;
  localparam logic [7:0] COPY_CMD = 8'h80;
  localparam logic [7:0] ZERO_CMD = 8'h00;

  typedef enum int {
    FLAW_NONE,
    FLAW_PARENT,
    FLAW_TARGET,
    FLAW_LONG_HEADER,
    FLAW_TRUNCATE,
    FLAW_CORRUPT
  } flaw_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_delta_byte = 8'h00;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_kind;
  logic [31:0] out_copy_offset;
  logic [23:0] out_copy_length;
  logic [7:0]  out_literal_byte;
  logic [31:0] out_object_size;
  logic [2:0]  out_error_code;
  logic        out_last;
  logic        cfg_wr_en = 1'b0;
  logic [31:0] cfg_wr_data = 32'h0;

  logic [31:0] parent_size_reg;
  phase_t      dec_phase;
  logic [63:0] size_acc;
  int unsigned shift_cnt;
  logic [63:0] parent_decl;
  logic [63:0] owed;
  logic [6:0]  flags;
  logic [63:0] off_acc;
  logic [31:0] len_acc;
  int          lit_left;
  bit          faulted;

  result_t     decoded_queue[$];
  result_t     byte_records[$];
  logic [7:0]  stream_q[$];
  logic [7:0]  body_q[$];

  int mismatch_count = 0;
  int live_items = 0;
  int in_gap_max = 0;
  int out_stall_max = 0;
  int sink_hold = 0;

  delta_stream_command_decoder #(.SIZE_BITS(SIZE_BITS)) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_delta_byte(in_delta_byte),
    .in_last_byte(in_last_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_kind(out_kind),
    .out_copy_offset(out_copy_offset),
    .out_copy_length(out_copy_length),
    .out_literal_byte(out_literal_byte),
    .out_object_size(out_object_size),
    .out_error_code(out_error_code),
    .out_last(out_last),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #5 clk = ~clk;

  function automatic void clear_stream();
    dec_phase = PH_PARENT;
    size_acc = '0;
    shift_cnt = 0;
    parent_decl = '0;
    owed = '0;
    flags = '0;
    off_acc = '0;
    len_acc = '0;
    lit_left = 0;
    faulted = 1'b0;
  endfunction

  function automatic result_t make_result(kind_t k, logic [31:0] off, logic [23:0] len,
                                          logic [7:0] lit, logic [31:0] tsz, err_t e);
    result_t r;
    r.kind = k;
    r.copy_offset = off;
    r.copy_length = len;
    r.literal_byte = lit;
    r.object_size = tsz;
    r.error_code = e;
    r.last = 1'b0;
    return r;
  endfunction

  // Returns -1 for an overlong size field, 1 when the field completes, 0 otherwise.
  function automatic int take_size_byte(logic [7:0] b);
    logic [6:0] payload;
    int unsigned room;
    payload = b[6:0];
    if (shift_cnt >= SIZE_BITS) return -1;
    room = SIZE_BITS - shift_cnt;
    if (room < 7 && (payload >> room) != 0) return -1;
    size_acc = size_acc | (64'(payload) << shift_cnt);
    shift_cnt = shift_cnt + 7;
    return b[7] ? 0 : 1;
  endfunction

  function automatic err_t close_copy();
    logic [63:0] len;
    len = 64'(len_acc);
    if (len == 0) len = 64'h10000;
    dec_phase = PH_CMD;
    if (off_acc + len > parent_decl || len > owed) return ERR_BADCOPY;
    byte_records.push_back(make_result(KIND_COPY, off_acc[31:0], len[23:0], '0, '0, ERR_NONE));
    owed = owed - len;
    return ERR_NONE;
  endfunction

  task automatic decode_byte(input logic [7:0] b, input logic lb);
    err_t err;
    int r;
    int k;
    err = ERR_NONE;
    live_items++;
    if (faulted) begin
      if (lb) clear_stream();
      return;
    end
    byte_records.delete();
    case (dec_phase)
      PH_PARENT: begin
        r = take_size_byte(b);
        if (r < 0) begin
          err = ERR_LONG;
        end else if (r == 1) begin
          parent_decl = size_acc;
          if (parent_decl != 64'(parent_size_reg)) begin
            err = ERR_PARENT;
          end else begin
            dec_phase = PH_TARGET;
            size_acc = '0;
            shift_cnt = 0;
          end
        end
      end
      PH_TARGET: begin
        r = take_size_byte(b);
        if (r < 0) begin
          err = ERR_LONG;
        end else if (r == 1) begin
          byte_records.push_back(make_result(KIND_TARGET, '0, '0, '0, size_acc[31:0], ERR_NONE));
          owed = size_acc;
          dec_phase = PH_CMD;
        end
      end
      PH_CMD: begin
        if (b[7]) begin
          flags = b[6:0];
          off_acc = '0;
          len_acc = '0;
          if (flags == 0) err = close_copy();
          else dec_phase = PH_COPY;
        end else if (b != ZERO_CMD) begin
          if (64'(b) > owed) begin
            err = ERR_OVERRUN;
          end else begin
            lit_left = b;
            owed = owed - 64'(b);
            dec_phase = PH_INSERT;
          end
        end else begin
          err = ERR_ZEROCMD;
        end
      end
      PH_COPY: begin
        k = 0;
        while (k < 7 && !flags[k]) k++;
        if (k < 4) off_acc = off_acc | (64'(b) << (8 * k));
        else if (k < 7) len_acc = len_acc | (32'(b) << (8 * (k - 4)));
        if (k < 7) flags[k] = 1'b0;
        if (flags == 0) err = close_copy();
      end
      PH_INSERT: begin
        byte_records.push_back(make_result(KIND_LITERAL, '0, '0, b, '0, ERR_NONE));
        if (lit_left > 0) lit_left--;
        if (lit_left == 0) dec_phase = PH_CMD;
      end
      default: dec_phase = PH_CMD;
    endcase
    if (err != ERR_NONE) begin
      byte_records.push_back(make_result(KIND_ERROR, '0, '0, '0, '0, err));
      faulted = 1'b1;
    end else if (lb) begin
      if (dec_phase == PH_CMD && owed == 0)
        byte_records.push_back(make_result(KIND_DONE, '0, '0, '0, '0, ERR_NONE));
      else
        byte_records.push_back(make_result(KIND_ERROR, '0, '0, '0, '0, ERR_TRUNC));
    end
    if (lb) clear_stream();
    if (byte_records.size() > 0) byte_records[byte_records.size() - 1].last = 1'b1;
    foreach (byte_records[i]) decoded_queue.push_back(byte_records[i]);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < MAX_PRINTED)
      $display("%0t mismatch %s: got %0h, want %0h", $time, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : record_compare
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (decoded_queue.size() == 0) begin
        report_mismatch("result with none pending, kind", 32'(out_kind), '0);
      end else begin
        want = decoded_queue.pop_front();
        if (out_kind !== want.kind)
          report_mismatch("kind", 32'(out_kind), 32'(want.kind));
        if (out_copy_offset !== want.copy_offset)
          report_mismatch("copy_offset", out_copy_offset, want.copy_offset);
        if (out_copy_length !== want.copy_length)
          report_mismatch("copy_length", 32'(out_copy_length), 32'(want.copy_length));
        if (out_literal_byte !== want.literal_byte)
          report_mismatch("literal_byte", 32'(out_literal_byte), 32'(want.literal_byte));
        if (out_object_size !== want.object_size)
          report_mismatch("object_size", out_object_size, want.object_size);
        if (out_error_code !== want.error_code)
          report_mismatch("error_code", 32'(out_error_code), 32'(want.error_code));
        if (out_last !== want.last)
          report_mismatch("last", 32'(out_last), 32'(want.last));
      end
    end
  end

  initial begin : result_sink
    int stall;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (sink_hold > 0) begin
        stall = sink_hold;
        sink_hold = 0;
      end else begin
        stall = $urandom_range(out_stall_max, 0);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid && sink_hold == 0);
      @(negedge clk);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("testbench: done, errors");
    $finish;
  end

  // Starts at a falling edge or just after a rising one; returns just after the accepting edge.
  task automatic send_byte(input logic [7:0] b, input logic lb);
    int gap;
    gap = $urandom_range(in_gap_max, 0);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_delta_byte <= b;
    in_last_byte <= lb;
    do @(posedge clk); while (!in_ready);
    decode_byte(b, lb);
  endtask

  task automatic release_input;
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_results_drained;
    release_input();
    while (decoded_queue.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_parent_size(input logic [31:0] value);
    wait_results_drained();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    parent_size_reg = value;
  endtask

  task automatic send_stream;
    int i;
    for (i = 0; i < stream_q.size(); i++)
      send_byte(stream_q[i], i == stream_q.size() - 1);
  endtask

  task automatic push_size(input logic [31:0] v, input bit pad, input bit overlong);
    logic [63:0] wide;
    logic [7:0] b;
    int n;
    int i;
    wide = 64'(v);
    n = 1;
    while (n < 5 && (wide >> (7 * n)) != 0) n++;
    if (pad) n = $urandom_range(5, n);
    if (overlong) n = ($urandom_range(1, 0) == 1) ? 6 : 5;
    for (i = 0; i < n; i++) begin
      b = {1'b0, wide[7 * i +: 7]};
      if (overlong && n == 5 && i == 4) b[6:4] = 3'($urandom_range(7, 1));
      if (i < n - 1) b[7] = 1'b1;
      stream_q.push_back(b);
    end
  endtask

  task automatic build_good_stream(input int n_cmds, input flaw_t flaw);
    logic [63:0] total;
    logic [63:0] len;
    logic [63:0] parent;
    logic [63:0] off;
    logic [31:0] target;
    logic [6:0]  cmd_flags;
    logic [7:0]  arg [7];
    int k;
    int c;
    int i;
    body_q.delete();
    stream_q.delete();
    parent = 64'(parent_size_reg);
    total = '0;
    for (c = 0; c < n_cmds; c++) begin
      if (parent != 0 && $urandom_range(1, 0) == 1) begin
        case ($urandom_range(3, 0))
          0: len = 64'h10000;
          1: len = 64'($urandom_range(32'hff_ffff, 1));
          default: len = 64'($urandom_range(64, 1));
        endcase
        if (len > parent) len = 64'($urandom_range(parent[31:0], 1));
        if ($urandom_range(3, 0) == 0) off = parent - len;
        else off = 64'($urandom_range(32'(parent - len), 0));
        for (i = 0; i < 4; i++) arg[i] = off[8 * i +: 8];
        for (i = 0; i < 3; i++) begin
          if (len == 64'h10000 && $urandom_range(1, 0) == 1) arg[4 + i] = 8'h00;
          else arg[4 + i] = len[8 * i +: 8];
        end
        for (i = 0; i < 7; i++)
          cmd_flags[i] = (arg[i] != 0) || ($urandom_range(3, 0) == 0);
        body_q.push_back(COPY_CMD | {1'b0, cmd_flags});
        for (i = 0; i < 7; i++)
          if (cmd_flags[i]) body_q.push_back(arg[i]);
        total = total + len;
      end else begin
        k = ($urandom_range(3, 0) == 0) ? $urandom_range(127, 1) : $urandom_range(6, 1);
        body_q.push_back(8'(k));
        repeat (k) body_q.push_back(8'($urandom_range(255, 0)));
        total = total + 64'(k);
      end
    end
    if (flaw == FLAW_PARENT) parent = parent ^ (64'h1 << $urandom_range(31, 0));
    target = total[31:0];
    if (flaw == FLAW_TARGET) begin
      case ($urandom_range(3, 0))
        0: target = 32'hffff_ffff;
        1: target = $urandom();
        2: target = total[31:0] + 32'd1;
        default: target = total[31:0] - 32'd1;
      endcase
    end
    k = $urandom_range(1, 0);
    push_size(parent[31:0], $urandom_range(3, 0) == 0, flaw == FLAW_LONG_HEADER && k == 0);
    push_size(target, $urandom_range(3, 0) == 0, flaw == FLAW_LONG_HEADER && k == 1);
    foreach (body_q[j]) stream_q.push_back(body_q[j]);
    if (flaw == FLAW_TRUNCATE && stream_q.size() > 1) begin
      k = $urandom_range(stream_q.size() - 1, 1);
      repeat (k) void'(stream_q.pop_back());
    end
    if (flaw == FLAW_CORRUPT) begin
      i = $urandom_range(stream_q.size() - 1, 0);
      stream_q[i] = 8'($urandom_range(255, 0));
    end
  endtask

  task automatic build_noise_stream;
    int k;
    stream_q.delete();
    k = $urandom_range(12, 1);
    repeat (k) stream_q.push_back(8'($urandom_range(255, 0)));
  endtask

  task automatic test_stream_headers;
    in_gap_max = 2;
    out_stall_max = 2;
    stream_q = '{8'h00, 8'h00};
    send_stream();
    stream_q = '{8'h00};
    send_stream();
    stream_q = '{8'h80, 8'h80, 8'h80, 8'h80, 8'h10};
    send_stream();
  endtask

  task automatic test_stream_faults;
    set_parent_size(32'd100);
    stream_q = '{8'h01, 8'h7f};
    send_stream();
    stream_q = '{8'h64, 8'h05, ZERO_CMD, 8'h11};
    send_stream();
    stream_q = '{8'h64, 8'h05, 8'h06};
    send_stream();
    stream_q = '{8'h64, 8'h05, COPY_CMD};
    send_stream();
  endtask

  task automatic test_copy_and_insert;
    stream_q = '{8'h64, 8'h04, COPY_CMD | 8'h11, 8'h60, 8'h04};
    send_stream();
    stream_q = '{8'h64, 8'h02, 8'h02, 8'h00, 8'hff};
    send_stream();
  endtask

  task automatic test_random_streams;
    logic [31:0] parent_sizes [6];
    int gaps [6];
    int stalls [6];
    int p;
    int sel;
    int goal;
    int streams;
    parent_sizes = '{32'h0, 32'hffff_ffff, 32'h1, 32'h0, 32'h0, 32'h7f};
    parent_sizes[3] = $urandom_range(5000, 2);
    parent_sizes[4] = $urandom();
    gaps = '{0, 15, 3, 0, 15, 6};
    stalls = '{0, 0, 15, 15, 3, 6};
    for (p = 0; p < 6; p++) begin
      set_parent_size(parent_sizes[p]);
      in_gap_max = gaps[p];
      out_stall_max = stalls[p];
      goal = live_items + 300;
      streams = 0;
      while (live_items < goal) begin
        sel = $urandom_range(99, 0);
        if (sel < 70) build_good_stream($urandom_range(6, 0), FLAW_NONE);
        else if (sel < 88) build_good_stream($urandom_range(4, 0), flaw_t'($urandom_range(5, 1)));
        else build_noise_stream();
        send_stream();
        streams++;
        if (streams % 12 == 0) wait_results_drained();
      end
    end
  endtask

  task automatic test_output_backpressure;
    int s;
    in_gap_max = 0;
    out_stall_max = 0;
    set_parent_size(32'd4096);
    sink_hold = 300;
    for (s = 0; s < 4; s++) begin
      build_good_stream(5, FLAW_NONE);
      send_stream();
    end
    wait_results_drained();
  endtask

  initial begin
    clear_stream();
    parent_size_reg = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_stream_headers();
    test_stream_faults();
    test_copy_and_insert();
    test_random_streams();
    test_output_backpressure();
    wait_results_drained();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) $display("testbench: done, clean");
    else $display("testbench: done, errors");
    $finish;
  end

endmodule

>>> sim.f
rtl/dscd_pkg.sv
rtl/dscd_decoder.sv
rtl/dscd_outq.sv
rtl/delta_stream_command_decoder.sv
tb/testbench.sv
